// ===== hw/rtl/wsa_pkg.sv =====
// Shared types and constants for the windowed score averager.
// Used by the channel interfaces and the top level; depends on nothing.
package wsa_pkg;

	localparam int TIME_W  = 31;
	localparam int SCORE_W = 64;
	localparam int CLS_W   = 3;
	localparam int MEAN_W  = 8;
	localparam int WIN_W   = 16;
	localparam int MINC_W  = 6;
	localparam int CFG_IDX_W = 1;

	localparam logic [7:0] SCORE_BIAS    = 8'h80;
	localparam int         QUARTER_SHIFT = 2;

	typedef logic [1:0] status_t;
	localparam status_t STATUS_OK    = 2'd0;
	localparam status_t STATUS_SHORT = 2'd1;
	localparam status_t STATUS_ORDER = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW    = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_COUNT = 1'd1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_PRUNE_RD,
		S_PRUNE,
		S_SUM,
		S_DIV_LOAD,
		S_DIV,
		S_EMIT
	} state_t;

endpackage

// ===== hw/rtl/wsa_in_if.sv =====
// Input channel: one classifier result item with valid/ready handshake.
// Depends on wsa_pkg for field widths.
interface wsa_in_if;
	logic                             valid;
	logic                             ready;
	logic [wsa_pkg::TIME_W-1:0]       time_ms;
	logic [wsa_pkg::SCORE_W-1:0]      score_vector;

	modport source (output valid, output time_ms, output score_vector, input ready);
	modport sink (input valid, input time_ms, input score_vector, output ready);
endinterface

// ===== hw/rtl/wsa_out_if.sv =====
// Output channel: one averaged-score result item with valid/ready handshake.
// Depends on wsa_pkg for field widths and the status type.
interface wsa_out_if;
	logic                        valid;
	logic                        ready;
	wsa_pkg::status_t            status;
	logic [wsa_pkg::CLS_W-1:0]   class_index;
	logic [wsa_pkg::MEAN_W-1:0]  mean_score;
	logic                        last;

	modport source (output valid, output status, output class_index, output mean_score,
		output last, input ready);
	modport sink (input valid, input status, input class_index, input mean_score,
		input last, output ready);
endinterface

// ===== hw/rtl/windowed_score_averager.sv =====
// Windowed score averager: top level with ring memories, sequencer and shared divider.
// Depends on wsa_pkg, wsa_in_if and wsa_out_if.
//
// Each input item is one timestamped vector of CLASSES signed byte scores. The block
// holds up to RING_DEPTH results in a ring, drops those older than window_ms, and
// answers with CLASSES mean items (score + 128, truncated), or with one status item
// when the timestamp is older than the oldest held result or too few results / too
// short a time span remain. Items are handled one at a time and the input is not
// ready until the last result item of the previous one is in the output register.
// After an item is accepted, the check state either sends an ordering error straight
// to the emit state or writes the item; a prune read and test then follow for each
// dropped result and once more, a not-ready answer goes to emit, and a full answer sums
// every held entry and runs the divider once per class. Each prune test and each
// summed entry uses the single read port of the ring, and each class mean takes one
// eight-step pass through the shared restoring divider. No clearing pass is needed.
module windowed_score_averager #(
	parameter int CLASSES    = 4,
	parameter int RING_DEPTH = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [wsa_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [wsa_pkg::WIN_W-1:0]         cfg_wdata,
	wsa_in_if.sink                            in_ch,
	wsa_out_if.source                         out_ch
);

	localparam int SLOT_W = $clog2(RING_DEPTH);
	localparam int CNT_W  = $clog2(RING_DEPTH + 1);
	localparam int SUM_W  = CNT_W + 8;
	localparam int AW     = CNT_W + 1;
	localparam int CMP_W  = (CNT_W > wsa_pkg::MINC_W) ? CNT_W : wsa_pkg::MINC_W;
	localparam int LANE_W = (CLASSES > 1) ? $clog2(CLASSES) : 1;
	localparam int TW     = wsa_pkg::TIME_W;

	wsa_pkg::state_t state_q, state_d;

	logic [wsa_pkg::WIN_W-1:0]  window_q;
	logic [wsa_pkg::MINC_W-1:0] min_count_q;

	logic [SLOT_W-1:0] oldest_q;
	logic [CNT_W-1:0]  count_q;

	logic [TW-1:0]               t_q;
	logic [wsa_pkg::SCORE_W-1:0] sv_q;

	logic [TW-1:0]               times_mem [RING_DEPTH];
	logic [wsa_pkg::SCORE_W-1:0] scores_mem [RING_DEPTH];
	logic [TW-1:0]               times_rd_q;
	logic [wsa_pkg::SCORE_W-1:0] scores_rd_q;

	logic [SLOT_W-1:0] ptr_q;
	logic [CNT_W-1:0]  idx_q;
	logic              data_vld_q;
	logic [SUM_W-1:0]  sums_q [CLASSES];

	logic [SUM_W-1:0]             rem_q;
	logic [wsa_pkg::MEAN_W-1:0]   quo_q;
	logic [2:0]                   bit_q;
	logic [wsa_pkg::CLS_W-1:0]    cls_q;
	wsa_pkg::status_t             res_status_q;

	logic                         out_vld_q;
	wsa_pkg::status_t             out_status_q;
	logic [wsa_pkg::CLS_W-1:0]    out_cls_q;
	logic [wsa_pkg::MEAN_W-1:0]   out_mean_q;
	logic                         out_last_q;

	logic                  ring_full;
	logic [SLOT_W-1:0]     oldest_inc;
	logic [SLOT_W-1:0]     ptr_inc;
	logic [AW-1:0]         app_sum;
	logic [SLOT_W-1:0]     wr_slot;
	logic [SLOT_W-1:0]     rd_addr;
	logic                  wr_en;
	logic                  order_err;
	logic                  too_old;
	logic                  not_ready;
	logic [SUM_W-1:0]      div_shift;
	logic                  div_ge;
	logic                  emit_ok;
	logic                  emit_load;
	logic                  last_class;
	logic [TW-1:0]         span;

	assign ring_full  = (count_q == CNT_W'(RING_DEPTH));
	assign oldest_inc = (oldest_q == SLOT_W'(RING_DEPTH - 1)) ? '0 : oldest_q + 1'b1;
	assign ptr_inc    = (ptr_q == SLOT_W'(RING_DEPTH - 1)) ? '0 : ptr_q + 1'b1;
	assign app_sum    = AW'(oldest_q) + AW'(count_q);
	assign wr_slot    = ring_full ? oldest_q :
		(app_sum >= AW'(RING_DEPTH)) ? SLOT_W'(app_sum - AW'(RING_DEPTH)) :
		SLOT_W'(app_sum);

	assign order_err = (count_q != '0) && (t_q < times_rd_q);
	assign too_old   = ({1'b0, times_rd_q} + (TW + 1)'(window_q)) < {1'b0, t_q};
	assign span      = t_q - times_rd_q;
	assign not_ready = (CMP_W'(count_q) < CMP_W'(min_count_q)) || (t_q < times_rd_q) ||
		(span < TW'(window_q >> wsa_pkg::QUARTER_SHIFT));

	assign div_shift  = SUM_W'(count_q) << bit_q;
	assign div_ge     = (rem_q >= div_shift);
	assign emit_ok    = !out_vld_q || out_ch.ready;
	assign last_class = (cls_q == wsa_pkg::CLS_W'(CLASSES - 1));

	always_comb begin
		state_d   = state_q;
		rd_addr   = oldest_q;
		wr_en     = 1'b0;
		emit_load = 1'b0;
		unique case (state_q)
			wsa_pkg::S_IDLE: begin
				if (in_ch.valid) begin
					state_d = wsa_pkg::S_CHECK;
				end
			end
			wsa_pkg::S_CHECK: begin
				if (order_err) begin
					state_d = wsa_pkg::S_EMIT;
				end else begin
					wr_en   = 1'b1;
					state_d = wsa_pkg::S_PRUNE_RD;
				end
			end
			wsa_pkg::S_PRUNE_RD: begin
				state_d = wsa_pkg::S_PRUNE;
			end
			wsa_pkg::S_PRUNE: begin
				if (too_old) begin
					state_d = wsa_pkg::S_PRUNE_RD;
				end else if (not_ready) begin
					state_d = wsa_pkg::S_EMIT;
				end else begin
					state_d = wsa_pkg::S_SUM;
				end
			end
			wsa_pkg::S_SUM: begin
				rd_addr = ptr_q;
				if (idx_q == count_q && !data_vld_q) begin
					state_d = wsa_pkg::S_DIV_LOAD;
				end
			end
			wsa_pkg::S_DIV_LOAD: begin
				state_d = wsa_pkg::S_DIV;
			end
			wsa_pkg::S_DIV: begin
				if (bit_q == 3'd0) begin
					state_d = wsa_pkg::S_EMIT;
				end
			end
			wsa_pkg::S_EMIT: begin
				if (emit_ok) begin
					emit_load = 1'b1;
					if (res_status_q == wsa_pkg::STATUS_OK && !last_class) begin
						state_d = wsa_pkg::S_DIV_LOAD;
					end else begin
						state_d = wsa_pkg::S_IDLE;
					end
				end
			end
			default: begin
				state_d = wsa_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wsa_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// ring storage: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			times_mem[wr_slot]  <= t_q;
			scores_mem[wr_slot] <= sv_q;
		end
		times_rd_q  <= times_mem[rd_addr];
		scores_rd_q <= scores_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q    <= wsa_pkg::WIN_W'(1000);
			min_count_q <= wsa_pkg::MINC_W'(3);
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				wsa_pkg::CFG_WINDOW:    window_q    <= cfg_wdata;
				wsa_pkg::CFG_MIN_COUNT: min_count_q <= cfg_wdata[wsa_pkg::MINC_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oldest_q   <= '0;
			count_q    <= '0;
			data_vld_q <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			if (state_q == wsa_pkg::S_CHECK && !order_err) begin
				if (ring_full) begin
					oldest_q <= oldest_inc;
				end else begin
					count_q <= count_q + 1'b1;
				end
			end
			if (state_q == wsa_pkg::S_PRUNE && too_old) begin
				oldest_q <= oldest_inc;
				count_q  <= count_q - 1'b1;
			end
			if (state_q == wsa_pkg::S_SUM) begin
				data_vld_q <= (idx_q != count_q);
			end else begin
				data_vld_q <= 1'b0;
			end
			if (emit_load) begin
				out_vld_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			wsa_pkg::S_IDLE: begin
				t_q  <= in_ch.time_ms;
				sv_q <= in_ch.score_vector;
			end
			wsa_pkg::S_CHECK: begin
				res_status_q <= wsa_pkg::STATUS_ORDER;
			end
			wsa_pkg::S_PRUNE: begin
				res_status_q <= not_ready ? wsa_pkg::STATUS_SHORT : wsa_pkg::STATUS_OK;
				ptr_q        <= oldest_q;
				idx_q        <= '0;
				cls_q        <= '0;
				for (int k = 0; k < CLASSES; k++) begin
					sums_q[k] <= '0;
				end
			end
			wsa_pkg::S_SUM: begin
				if (idx_q != count_q) begin
					ptr_q <= ptr_inc;
					idx_q <= idx_q + 1'b1;
				end
				if (data_vld_q) begin
					for (int k = 0; k < CLASSES; k++) begin
						sums_q[k] <= sums_q[k] +
							SUM_W'(scores_rd_q[8*k +: 8] ^ wsa_pkg::SCORE_BIAS);
					end
				end
			end
			wsa_pkg::S_DIV_LOAD: begin
				rem_q <= sums_q[cls_q[LANE_W-1:0]];
				quo_q <= '0;
				bit_q <= 3'd7;
			end
			wsa_pkg::S_DIV: begin
				if (div_ge) begin
					rem_q <= rem_q - div_shift;
				end
				quo_q <= {quo_q[wsa_pkg::MEAN_W-2:0], div_ge};
				bit_q <= bit_q - 1'b1;
			end
			wsa_pkg::S_EMIT: begin
				if (emit_ok) begin
					cls_q <= cls_q + 1'b1;
				end
			end
			default: ;
		endcase
		if (emit_load) begin
			out_status_q <= res_status_q;
			if (res_status_q == wsa_pkg::STATUS_OK) begin
				out_cls_q  <= cls_q;
				out_mean_q <= quo_q;
				out_last_q <= last_class;
			end else begin
				out_cls_q  <= '0;
				out_mean_q <= '0;
				out_last_q <= 1'b1;
			end
		end
	end

	assign in_ch.ready         = (state_q == wsa_pkg::S_IDLE);
	assign out_ch.valid        = out_vld_q;
	assign out_ch.status       = out_status_q;
	assign out_ch.class_index  = out_cls_q;
	assign out_ch.mean_score   = out_mean_q;
	assign out_ch.last         = out_last_q;

endmodule

// ===== dv/tb_windowed_score_averager.sv =====
// Self-checking testbench for the windowed score averager: directed and random items,
// a local prediction of the window means and a result checker with random stalls.
// Depends on wsa_pkg, wsa_in_if, wsa_out_if and windowed_score_averager.
module tb_windowed_score_averager;

	localparam int CLASSES      = 4;
	localparam int RING_DEPTH   = 32;
	localparam int DRAIN_CYCLES = 8;
	localparam int TAIL_CYCLES  = 200;
	localparam int CYCLE_LIMIT  = 600000;

	typedef struct packed {
		wsa_pkg::status_t           status;
		logic [wsa_pkg::CLS_W-1:0]  cls;
		logic [wsa_pkg::MEAN_W-1:0] mean;
		logic                       last;
	} mean_item_t;

	logic                          clk = 1'b0;
	logic                          arst_n;
	logic                          cfg_wr_en;
	logic [wsa_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [wsa_pkg::WIN_W-1:0]     cfg_wdata;

	wsa_in_if  in_ch ();
	wsa_out_if out_ch ();

	windowed_score_averager #(
		.CLASSES   (CLASSES),
		.RING_DEPTH(RING_DEPTH)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.in_ch    (in_ch),
		.out_ch   (out_ch)
	);

	// window state as the block should hold it
	logic [wsa_pkg::WIN_W-1:0]   win_ms;
	logic [wsa_pkg::MINC_W-1:0]  min_results;
	logic [wsa_pkg::TIME_W-1:0]  held_times [RING_DEPTH];
	logic [wsa_pkg::SCORE_W-1:0] held_scores [RING_DEPTH];
	int                          oldest_slot;
	int                          held_count;

	mean_item_t                  expected_means [$];
	logic [wsa_pkg::TIME_W-1:0]  clock_ms;
	int                          tx_idle_pct;
	int                          rx_idle_pct;
	int                          mismatches;
	int                          cycle_count;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	function automatic void note_mismatch(input string field, input logic [31:0] want,
		input logic [31:0] got);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch in %s: expected %0d, got %0d", field, want, got);
	endfunction

	function automatic void queue_status(input wsa_pkg::status_t s);
		mean_item_t item;
		item.status = s;
		item.cls    = '0;
		item.mean   = '0;
		item.last   = 1'b1;
		expected_means = {expected_means, item};
	endfunction

	function automatic void predict_means(input logic [wsa_pkg::TIME_W-1:0] t,
		input logic [wsa_pkg::SCORE_W-1:0] sv);
		longint       cutoff;
		longint       span;
		int unsigned  sums [CLASSES];
		logic [63:0]  v;
		mean_item_t   item;
		if (held_count > 0 && t < held_times[oldest_slot]) begin
			queue_status(wsa_pkg::STATUS_ORDER);
			return;
		end
		if (held_count >= RING_DEPTH) begin
			oldest_slot = (oldest_slot + 1) % RING_DEPTH;
			held_count  = RING_DEPTH - 1;
		end
		held_times[(oldest_slot + held_count) % RING_DEPTH]  = t;
		held_scores[(oldest_slot + held_count) % RING_DEPTH] = sv;
		held_count++;
		cutoff = longint'(t) - longint'(win_ms);
		while (held_count > 0 && longint'(held_times[oldest_slot]) < cutoff) begin
			oldest_slot = (oldest_slot + 1) % RING_DEPTH;
			held_count--;
		end
		span = longint'(t) - longint'(held_times[oldest_slot]);
		if (held_count < int'(min_results) || span < longint'(win_ms >> 2)) begin
			queue_status(wsa_pkg::STATUS_SHORT);
			return;
		end
		for (int k = 0; k < CLASSES; k++)
			sums[k] = 0;
		for (int i = 0; i < held_count; i++) begin
			v = held_scores[(oldest_slot + i) % RING_DEPTH];
			for (int k = 0; k < CLASSES; k++)
				sums[k] += 32'(v[8*k +: 8] ^ wsa_pkg::SCORE_BIAS);
		end
		for (int k = 0; k < CLASSES; k++) begin
			item.status = wsa_pkg::STATUS_OK;
			item.cls    = wsa_pkg::CLS_W'(k);
			item.mean   = wsa_pkg::MEAN_W'(sums[k] / held_count);
			item.last   = (k == CLASSES - 1);
			expected_means = {expected_means, item};
		end
	endfunction

	always @(posedge clk) begin : check_means
		mean_item_t want;
		if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
			if (expected_means.size() == 0) begin
				note_mismatch("item with none outstanding", 32'd0, 32'd1);
			end else begin
				want = expected_means[0];
				expected_means.delete(0);
				if (out_ch.status !== want.status)
					note_mismatch("status", 32'(want.status), 32'(out_ch.status));
				if (out_ch.class_index !== want.cls)
					note_mismatch("class_index", 32'(want.cls), 32'(out_ch.class_index));
				if (out_ch.mean_score !== want.mean)
					note_mismatch("mean_score", 32'(want.mean), 32'(out_ch.mean_score));
				if (out_ch.last !== want.last)
					note_mismatch("last", 32'(want.last), 32'(out_ch.last));
			end
		end
	end

	task automatic send_item(input logic [wsa_pkg::TIME_W-1:0] t,
		input logic [wsa_pkg::SCORE_W-1:0] sv);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid        <= 1'b1;
		in_ch.time_ms      <= t;
		in_ch.score_vector <= sv;
		@(posedge clk);
		while (in_ch.ready !== 1'b1)
			@(posedge clk);
		predict_means(t, sv);
		if (t > clock_ms)
			clock_ms = t;
	endtask

	// hold the sender until every outstanding result is back
	task automatic drain_results();
		in_ch.valid <= 1'b0;
		while (expected_means.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_setting(input logic [wsa_pkg::CFG_IDX_W-1:0] idx,
		input logic [wsa_pkg::WIN_W-1:0] value);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
		if (idx == wsa_pkg::CFG_WINDOW)
			win_ms = value;
		else
			min_results = value[wsa_pkg::MINC_W-1:0];
	endtask

	task automatic apply_settings(input logic [wsa_pkg::WIN_W-1:0] window,
		input logic [wsa_pkg::MINC_W-1:0] minc);
		drain_results();
		write_setting(wsa_pkg::CFG_WINDOW, window);
		write_setting(wsa_pkg::CFG_MIN_COUNT, wsa_pkg::WIN_W'(minc));
	endtask

	task automatic send_random_items(input int count, input int step_max);
		logic [wsa_pkg::TIME_W-1:0]  t;
		logic [wsa_pkg::SCORE_W-1:0] sv;
		int unsigned                 choice;
		for (int n = 0; n < count; n++) begin
			sv = {$urandom, $urandom};
			if ($urandom_range(9) == 0) begin
				for (int b = 0; b < 8; b++)
					case ($urandom_range(3))
						0: sv[8*b +: 8] = 8'h80;
						1: sv[8*b +: 8] = 8'h7F;
						2: sv[8*b +: 8] = 8'h00;
						default: sv[8*b +: 8] = 8'hFF;
					endcase
			end
			choice = $urandom_range(99);
			if (choice < 10 && held_count > 0 && held_times[oldest_slot] > 0) begin
				t = wsa_pkg::TIME_W'($urandom_range(held_times[oldest_slot] - 1, 0));
			end else if (choice < 22 && held_count > 0) begin
				t = wsa_pkg::TIME_W'($urandom_range(clock_ms, held_times[oldest_slot]));
			end else if (choice < 27) begin
				t = wsa_pkg::TIME_W'(clock_ms + win_ms + $urandom_range(5000));
			end else begin
				t = wsa_pkg::TIME_W'(clock_ms + $urandom_range(step_max));
			end
			send_item(t, sv);
		end
	endtask

	task automatic test_basic_window();
		send_item(31'd0, {8{8'h80}});
		send_item(31'd100, {8{8'h7F}});
		send_item(31'd300, {8{8'hFF}});
		send_item(31'd200, {8{8'h00}});
		send_item(31'd1250, 64'h0123_4567_89AB_CDEF);
		send_item(31'd299, 64'hFEDC_BA98_7654_3210);
	endtask

	task automatic test_negative_span();
		apply_settings(16'd0, 6'd1);
		send_item(31'd2000, 64'h5A5A_5A5A_A5A5_A5A5);
		apply_settings(16'hFFFF, 6'd1);
		send_item(31'd2500, 64'h8081_7F7E_0102_FEFD);
		send_item(31'd2100, 64'h0000_0000_FFFF_FFFF);
		apply_settings(16'd100, 6'd1);
		send_item(31'd2200, 64'hFFFF_FFFF_0000_0000);
	endtask

	task automatic test_zero_threshold();
		apply_settings(16'd0, 6'd0);
		send_item(31'd3000, 64'h1122_3344_5566_7788);
		send_item(31'd3000, 64'h99AA_BBCC_DDEE_FF00);
	endtask

	task automatic test_full_ring();
		apply_settings(16'hFFFF, 6'd32);
		clock_ms = wsa_pkg::TIME_W'(clock_ms + 100000);
		for (int n = 0; n < RING_DEPTH + 4; n++)
			send_item(wsa_pkg::TIME_W'(clock_ms + 1000), {$urandom, $urandom});
	endtask

	task automatic test_random_traffic(input int tx_pct, input int rx_pct, input int count);
		logic [wsa_pkg::WIN_W-1:0]  w;
		logic [wsa_pkg::MINC_W-1:0] m;
		int                         step_max;
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		for (int c = 0; c < 3; c++) begin
			case ($urandom_range(9))
				0: w = 16'd0;
				1, 2: w = 16'hFFFF;
				3, 4: w = wsa_pkg::WIN_W'($urandom_range(200, 1));
				default: w = wsa_pkg::WIN_W'($urandom_range(65535, 1));
			endcase
			case ($urandom_range(9))
				0: m = 6'd0;
				1: m = 6'd32;
				default: m = wsa_pkg::MINC_W'($urandom_range(8, 1));
			endcase
			step_max = $urandom_range(1) ? (int'(w) / 48 + 1) : (int'(w) / 6 + 1);
			apply_settings(w, m);
			send_random_items(count / 3, step_max);
		end
	endtask

	// the oldest entry ends at the top of the time range, so this runs last
	task automatic test_time_limit();
		apply_settings(16'd0, 6'd0);
		send_item({wsa_pkg::TIME_W{1'b1}}, {8{8'hFF}});
		send_item({wsa_pkg::TIME_W{1'b1}}, {$urandom, $urandom});
		send_item(31'd1, {$urandom, $urandom});
	endtask

	initial begin
		arst_n             <= 1'b0;
		cfg_wr_en          <= 1'b0;
		cfg_index          <= wsa_pkg::CFG_WINDOW;
		cfg_wdata          <= '0;
		in_ch.valid        <= 1'b0;
		in_ch.time_ms      <= '0;
		in_ch.score_vector <= '0;
		win_ms      = 16'd1000;
		min_results = 6'd3;
		oldest_slot = 0;
		held_count  = 0;
		clock_ms    = '0;
		tx_idle_pct = 16;
		rx_idle_pct = 56;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_basic_window();
		test_negative_span();
		test_zero_threshold();
		test_full_ring();
		test_random_traffic(16, 56, 60);
		test_random_traffic(56, 16, 60);
		test_random_traffic(0, 0, 60);
		test_time_limit();

		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
